// ----- rtl/uint_to_decimal_ascii_core_macros.svh -----
// assertion macros used by the converter rtl
`ifndef UINT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define UINT_TO_DECIMAL_ASCII_CORE_MACROS_SVH

`ifndef SYNTHESIS

// checked only while reset is released
`define UDA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define UDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define UDA_ASSERT(lbl, clk, rst_n, prop, msg)

`define UDA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/uda_pkg.sv -----
// types and constants of the binary to ascii decimal converter
package uda_pkg;

  localparam int unsigned VALUE_BITS = 32;
  // digits needed for the largest value: floor(bits * log10(2)) + 1
  localparam int unsigned NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCD_W      = NUM_DIGITS * 4;
  localparam int unsigned BIT_W      = $clog2(VALUE_BITS);
  localparam int unsigned DIG_W      = $clog2(NUM_DIGITS);

  localparam logic [7:0] ASCII_ZERO = 8'd48;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [7:0]            delimiter;
  } in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic shift_digit;
    logic emit_digit;
    logic emit_delim;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bit_done;
    logic top_zero;
    logic digit_last;
  } sts_t;

endpackage

// ----- rtl/uda_datapath.sv -----
// shift-add-3 binary to bcd datapath and character register
module uda_datapath import uda_pkg::*; (
  input  logic       clk_i,
  input  in_t        item_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output logic [7:0] char_o
);

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic [BCD_W-1:0]      bcd_adj;
  logic [BIT_W-1:0]      bit_cnt_q, bit_cnt_d;
  logic [DIG_W-1:0]      dig_cnt_q, dig_cnt_d;
  logic [7:0]            delim_q, delim_d;
  logic [7:0]            char_q, char_d;
  logic [3:0]            top_digit;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  assign top_digit = bcd_q[BCD_W-1 -: 4];

  always_comb begin
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    delim_d   = delim_q;
    char_d    = char_q;
    if (cmd_i.load) begin
      bin_d     = item_i.value;
      bcd_d     = '0;
      bit_cnt_d = '0;
      dig_cnt_d = '0;
      delim_d   = item_i.delimiter;
    end
    if (cmd_i.conv_step) begin
      bcd_d     = {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
      bin_d     = {bin_q[VALUE_BITS-2:0], 1'b0};
      bit_cnt_d = bit_cnt_q + 1'b1;
    end
    if (cmd_i.shift_digit) begin
      bcd_d     = {bcd_q[BCD_W-5:0], 4'd0};
      dig_cnt_d = dig_cnt_q + 1'b1;
    end
    if (cmd_i.emit_digit) begin
      char_d = ASCII_ZERO + {4'd0, top_digit};
    end
    if (cmd_i.emit_delim) begin
      char_d = delim_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    bit_cnt_q <= bit_cnt_d;
    dig_cnt_q <= dig_cnt_d;
    delim_q   <= delim_d;
    char_q    <= char_d;
  end

  assign sts_o.bit_done   = (bit_cnt_q == BIT_W'(VALUE_BITS - 1));
  assign sts_o.top_zero   = (top_digit == 4'd0);
  assign sts_o.digit_last = (dig_cnt_q == DIG_W'(NUM_DIGITS - 1));
  assign char_o           = char_q;

endmodule

// ----- rtl/uda_ctrl.sv -----
// sequencer for conversion, leading zero skip and character output
`include "uint_to_decimal_ascii_core_macros.svh"
module uda_ctrl import uda_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic strobe_o,
  output logic last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT,
    ST_DELIM
  } state_e;

  state_e state_q;
  logic   strobe_q;
  logic   last_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = start;
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
      end
      ST_SKIP: begin
        cmd_o.shift_digit = 1'b1;
        // the units digit is always shown, even when zero
        cmd_o.emit_digit  = !sts_i.top_zero || sts_i.digit_last;
      end
      ST_EMIT: begin
        cmd_o.shift_digit = 1'b1;
        cmd_o.emit_digit  = 1'b1;
      end
      ST_DELIM: begin
        cmd_o.emit_delim = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= cmd_o.emit_digit || cmd_o.emit_delim;
      last_q   <= cmd_o.emit_delim;
      case (state_q)
        ST_IDLE: begin
          if (start) state_q <= ST_CONV;
        end
        ST_CONV: begin
          if (sts_i.bit_done) state_q <= ST_SKIP;
        end
        ST_SKIP: begin
          if (cmd_o.emit_digit) begin
            state_q <= sts_i.digit_last ? ST_DELIM : ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (sts_i.digit_last) state_q <= ST_DELIM;
        end
        ST_DELIM: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign strobe_o = strobe_q;
  assign last_o   = last_q;

  `UDA_ASSERT(a_start_conv, clk_i, rst_ni, (start && !busy_o) |=> (state_q == ST_CONV), "accepted word did not start conversion")
  `UDA_ASSERT(a_digits_run, clk_i, rst_ni, (strobe_q && !last_q) |=> strobe_q, "gap in character run before delimiter")
  `UDA_ASSERT(a_quiet_conv, clk_i, rst_ni, (state_q == ST_CONV) |-> !strobe_q, "character strobed during conversion")
  `UDA_ASSERT_ALWAYS(a_last_strobe, clk_i, last_q |-> strobe_q, "last flag without strobe")

endmodule

// ----- rtl/uint_to_decimal_ascii_core.sv -----
// top level of the unsigned binary to ascii decimal converter
//
// Takes a 32-bit unsigned value and a delimiter byte when start is high and
// busy is low, then sends the decimal digits as ascii, most significant first
// without leading zeros (zero gives a single '0'), followed by the delimiter
// with last set. Each character is marked by result_strobe_o, high for a
// single cycle; the receiver cannot stall, so it must take every word
// as it comes. Characters of one value arrive on consecutive cycles. The
// conversion is a shift-add-3 loop taking one bit per cycle, then the bcd
// register is scanned one digit per cycle: leading zero digits are shifted
// out without output. The run takes equally long whatever the value; busy is
// low in the cycle in which the delimiter is on result_o, so the next word is
// accepted at the edge that ends that cycle.
module uint_to_decimal_ascii_core import uda_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  in_t  item_i,
  output logic busy,
  output logic result_strobe_o,
  output out_t result_o
);

  cmd_t       cmd;
  sts_t       sts;
  logic [7:0] char;
  logic       last;

  uda_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .strobe_o (result_strobe_o),
    .last_o   (last)
  );

  uda_datapath u_datapath (
    .clk_i  (clk_i),
    .item_i (item_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .char_o (char)
  );

  assign result_o.character = char;
  assign result_o.last      = last;

endmodule

// ----- test/tb.sv -----
// testbench for the binary to ascii decimal converter: directed and random values
module tb;
  import uda_pkg::*;

  // holds the characters still owed by the block and checks each word against them
  class char_ledger;
    out_t        owed[$];
    int unsigned failures;
    int unsigned values_seen;
    int unsigned chars_checked;
    bit          len_hit[1:NUM_DIGITS];

    function new();
      failures = 0;
      values_seen = 0;
      chars_checked = 0;
      foreach (len_hit[i]) len_hit[i] = 1'b0;
    endfunction

    function void note_value(in_t word);
      logic [VALUE_BITS-1:0] rest;
      logic [7:0]            digits[$];
      out_t                  c;
      rest = word.value;
      // peel digits off the low end, then send them high end first
      do begin
        digits.push_front(8'(rest % 10));
        rest = rest / 10;
      end while (rest != 0);
      len_hit[digits.size()] = 1'b1;
      foreach (digits[i]) begin
        c.character = ASCII_ZERO + digits[i];
        c.last = 1'b0;
        owed.push_back(c);
      end
      c.character = word.delimiter;
      c.last = 1'b1;
      owed.push_back(c);
      values_seen++;
    endfunction

    function void check_char(out_t got);
      out_t want;
      if (owed.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("tb: unexpected word char=%02h last=%0b", got.character, got.last);
        return;
      end
      want = owed.pop_front();
      chars_checked++;
      if (got.character !== want.character || got.last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("tb: mismatch expected char=%02h last=%0b, got char=%02h last=%0b",
                   want.character, want.last, got.character, got.last);
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function bit all_lengths();
      foreach (len_hit[i]) if (!len_hit[i]) return 1'b0;
      return 1'b1;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  in_t  item_i;
  logic busy;
  logic result_strobe_o;
  out_t result_o;

  char_ledger ledger = new();

  uint_to_decimal_ascii_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .item_i         (item_i),
    .busy           (busy),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // words are taken at the edge, so sample the values from just before it
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) ledger.check_char(result_o);
    if (rst_ni && start && !busy) ledger.note_value(item_i);
  end

  task automatic send_value(input logic [VALUE_BITS-1:0] v, input logic [7:0] d,
                            input bit allow_idle);
    int   gap;
    in_t  word;
    gap = 0;
    // some values are preceded by a gap so the block really sits idle
    if (allow_idle && $urandom_range(99, 0) < 18) gap = $urandom_range(90, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word.value = v;
    word.delimiter = d;
    start <= 1'b1;
    item_i <= word;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    int unsigned           ndig;
    logic [VALUE_BITS-1:0] lo;
    logic [VALUE_BITS-1:0] hi;
    if ($urandom_range(99, 0) < 15) return $urandom;
    ndig = $urandom_range(NUM_DIGITS, 1);
    lo = (ndig == 1) ? 0 : 1;
    for (int i = 1; i < ndig; i++) lo = lo * 10;
    hi = (ndig == NUM_DIGITS) ? '1 : lo * 10 - 1;
    if (ndig == 1) hi = 9;
    return $urandom_range(hi, lo);
  endfunction

  function automatic logic [7:0] pick_delim();
    case ($urandom_range(3, 0))
      0: return 8'h0a;
      1: return 8'h20;
      2: return 8'h2c;
      default: return 8'($urandom);
    endcase
  endfunction

  logic [VALUE_BITS-1:0] edge_vals[20] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd100000, 32'd99999,
    32'd100000000, 32'd999999999, 32'd1000000000, 32'd4294967295,
    32'd4294967294, 32'h8000_0000, 32'h7fff_ffff, 32'haaaa_aaaa,
    32'h5555_5555, 32'd12345, 32'd1000000001, 32'd0
  };
  logic [7:0] edge_delims[20] = '{
    8'h0a, 8'h00, 8'hff, 8'haa, 8'h55, 8'h20, 8'h0a, 8'h2c,
    8'h30, 8'h39, 8'h0d, 8'h00, 8'hff, 8'h0a, 8'h0a, 8'h55,
    8'haa, 8'h3b, 8'h09, 8'hff
  };

  initial begin
    start = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (edge_vals[i]) send_value(edge_vals[i], edge_delims[i], 1'b1);

    for (int n = 0; n < 240; n++) begin
      if (n == 120) begin
        // hold off until the block has drained everything owed
        start <= 1'b0;
        do @(posedge clk_i); while (ledger.pending() != 0);
      end
      // back to back stretch with no gaps
      send_value(pick_value(), pick_delim(), !(n >= 40 && n < 110));
    end
    start <= 1'b0;

    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    ledger.failures += ledger.pending();

    $display("tb: %0d values sent, %0d characters compared", ledger.values_seen,
             ledger.chars_checked);
    $display("tb: every digit count from 1 to %0d seen: %s", NUM_DIGITS,
             ledger.all_lengths() ? "yes" : "no");
    if (ledger.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
